// ===== design/frt_pkg.sv =====
// Shared types and constants for the frame rotate, flip and transpose engine.
`default_nettype none

package frt_pkg;

    localparam int MAX_WIDTH    = 256;
    localparam int MAX_HEIGHT   = 256;
    localparam int CHANNEL_BITS = 16;
    localparam int COORD_BITS   = 8;
    localparam int SIZE_BITS    = 9;
    localparam int PIXEL_BITS   = 3 * CHANNEL_BITS;
    localparam int STORE_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_BITS    = $clog2(STORE_DEPTH);
    localparam int CFG_IDX_BITS = 2;
    localparam int MODE_BITS    = 3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MODE   = 2'd2;

    localparam logic [MODE_BITS-1:0] MODE_IDENTITY  = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_ROT90     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_ROT180    = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_ROT270    = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_FLIP_H    = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_FLIP_V    = 3'd5;
    localparam logic [MODE_BITS-1:0] MODE_TRANSPOSE = 3'd6;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic [COORD_BITS-1:0]   src_col;
        logic [COORD_BITS-1:0]   src_row;
        logic [CHANNEL_BITS-1:0] red_in;
        logic [CHANNEL_BITS-1:0] green_in;
        logic [CHANNEL_BITS-1:0] blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red_out;
        logic [CHANNEL_BITS-1:0] green_out;
        logic [CHANNEL_BITS-1:0] blue_out;
        logic [COORD_BITS-1:0]   out_col;
        logic [COORD_BITS-1:0]   out_row;
        logic                    frame_last;
    } t_out_item;

endpackage

`default_nettype wire

// ===== design/frame_rotate_flip_transpose.sv =====
// Frame rotate, flip and transpose engine: top level with frame store.
//
// Input channel (i_in_valid / o_in_ready, i_in_item): a load item writes one
// source pixel into the frame store at its output position for the current
// mode; loads outside the configured size are dropped. A read item returns
// the next output pixel in raster order, with its position and a last flag,
// then wraps to the start after the last pixel.
// Output channel (o_out_valid / i_out_ready, o_out_item): one item per read.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data): width,
// height and mode; always ready, to be written while the block is idle.
// Timing: one item per cycle while no stalled read holds the input. A read
// result is valid once the item has passed these registers in order: the mapped
// position is registered, then its address multiply feeds the single-port
// frame store, whose read data is registered.
// A stalled receiver holds the output register; the input keeps taking items
// while loads drain or while the output register is free or being taken.
// Reset clears the read position, the pipeline and the registers to 256 x 256
// identity. Store contents are undefined until written; no clearing pass.
`default_nettype none

module frame_rotate_flip_transpose
    import frt_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire t_in_item                i_in_item,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output t_out_item                    o_out_item,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  wire logic [SIZE_BITS-1:0]    i_cfg_data
);

    logic [SIZE_BITS-1:0]  r_width, r_height;
    logic [MODE_BITS-1:0]  r_mode;
    logic [COORD_BITS-1:0] r_rd_col, r_rd_row;
    logic [COORD_BITS-1:0] n_rd_col, n_rd_row;

    logic                  r_s1_valid, r_s1_op, r_s1_last;
    logic [COORD_BITS-1:0] r_s1_col, r_s1_row;
    logic [PIXEL_BITS-1:0] r_s1_pix;

    logic                  r_out_valid, r_out_last;
    logic [COORD_BITS-1:0] r_out_col, r_out_row;
    logic [PIXEL_BITS-1:0] r_rd_data;

    logic [PIXEL_BITS-1:0] mem [STORE_DEPTH];

    logic [SIZE_BITS-1:0]  w_eff, h_eff, ow, oh;
    logic [SIZE_BITS-1:0]  c9, r9, map_col, map_row;
    logic [SIZE_BITS-1:0]  col_inc, row_inc;
    logic [COORD_BITS-1:0] cur_col, cur_row;
    logic                  swap, load_ok, out_range, cur_last;
    logic                  in_fire, s1_move, out_free, mem_we, mem_re;
    logic [ADDR_BITS:0]    prod, addr_sum;
    logic [ADDR_BITS-1:0]  addr;

    // Effective sizes and output frame shape
    always_comb begin
        if (r_width == '0) begin
            w_eff = SIZE_BITS'(1);
        end else if (r_width > SIZE_BITS'(MAX_WIDTH)) begin
            w_eff = SIZE_BITS'(MAX_WIDTH);
        end else begin
            w_eff = r_width;
        end
        if (r_height == '0) begin
            h_eff = SIZE_BITS'(1);
        end else if (r_height > SIZE_BITS'(MAX_HEIGHT)) begin
            h_eff = SIZE_BITS'(MAX_HEIGHT);
        end else begin
            h_eff = r_height;
        end
        swap = (r_mode == MODE_ROT90) || (r_mode == MODE_ROT270) ||
               (r_mode == MODE_TRANSPOSE);
        ow = swap ? h_eff : w_eff;
        oh = swap ? w_eff : h_eff;
    end

    // Destination position of a load
    always_comb begin
        c9 = {1'b0, i_in_item.src_col};
        r9 = {1'b0, i_in_item.src_row};
        load_ok = (c9 < w_eff) && (r9 < h_eff);
        unique case (r_mode)
            MODE_ROT90: begin
                map_col = h_eff - SIZE_BITS'(1) - r9;
                map_row = c9;
            end
            MODE_ROT180: begin
                map_col = w_eff - SIZE_BITS'(1) - c9;
                map_row = h_eff - SIZE_BITS'(1) - r9;
            end
            MODE_ROT270: begin
                map_col = r9;
                map_row = w_eff - SIZE_BITS'(1) - c9;
            end
            MODE_FLIP_H: begin
                map_col = w_eff - SIZE_BITS'(1) - c9;
                map_row = r9;
            end
            MODE_FLIP_V: begin
                map_col = c9;
                map_row = h_eff - SIZE_BITS'(1) - r9;
            end
            MODE_TRANSPOSE: begin
                map_col = r9;
                map_row = c9;
            end
            default: begin
                map_col = c9;
                map_row = r9;
            end
        endcase
    end

    // Read position and its successor
    always_comb begin
        out_range = ({1'b0, r_rd_col} >= ow) || ({1'b0, r_rd_row} >= oh);
        cur_col   = out_range ? '0 : r_rd_col;
        cur_row   = out_range ? '0 : r_rd_row;
        cur_last  = ({1'b0, cur_col} == ow - SIZE_BITS'(1)) &&
                    ({1'b0, cur_row} == oh - SIZE_BITS'(1));
        col_inc   = {1'b0, cur_col} + SIZE_BITS'(1);
        row_inc   = {1'b0, cur_row} + SIZE_BITS'(1);
        if (col_inc >= ow) begin
            n_rd_col = '0;
            n_rd_row = (row_inc >= oh) ? '0 : row_inc[COORD_BITS-1:0];
        end else begin
            n_rd_col = col_inc[COORD_BITS-1:0];
            n_rd_row = cur_row;
        end
    end

    // Handshakes
    assign out_free    = !r_out_valid || i_out_ready;
    assign s1_move     = r_s1_valid && ((r_s1_op == OP_LOAD) || out_free);
    assign o_in_ready  = !r_s1_valid || s1_move;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    // Store address: output raster index
    assign prod     = {{(ADDR_BITS+1-COORD_BITS){1'b0}}, r_s1_row} *
                      {{(ADDR_BITS+1-SIZE_BITS){1'b0}}, ow};
    assign addr_sum = prod + (ADDR_BITS+1)'(r_s1_col);
    assign addr     = addr_sum[ADDR_BITS-1:0];
    assign mem_we   = s1_move && (r_s1_op == OP_LOAD);
    assign mem_re   = s1_move && (r_s1_op == OP_READ);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[addr] <= r_s1_pix;
        end
        if (mem_re) begin
            r_rd_data <= mem[addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= SIZE_BITS'(MAX_WIDTH);
            r_height    <= SIZE_BITS'(MAX_HEIGHT);
            r_mode      <= MODE_IDENTITY;
            r_rd_col    <= '0;
            r_rd_row    <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    CFG_MODE:   r_mode   <= i_cfg_data[MODE_BITS-1:0];
                    default:    ;
                endcase
            end
            if (in_fire && (i_in_item.operation == OP_READ)) begin
                r_rd_col <= n_rd_col;
                r_rd_row <= n_rd_row;
            end
            if (in_fire) begin
                r_s1_valid <= (i_in_item.operation == OP_READ) || load_ok;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (mem_re) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op  <= i_in_item.operation;
            r_s1_pix <= {i_in_item.red_in, i_in_item.green_in, i_in_item.blue_in};
            if (i_in_item.operation == OP_READ) begin
                r_s1_col  <= cur_col;
                r_s1_row  <= cur_row;
                r_s1_last <= cur_last;
            end else begin
                r_s1_col  <= map_col[COORD_BITS-1:0];
                r_s1_row  <= map_row[COORD_BITS-1:0];
                r_s1_last <= 1'b0;
            end
        end
        if (mem_re) begin
            r_out_col  <= r_s1_col;
            r_out_row  <= r_s1_row;
            r_out_last <= r_s1_last;
        end
    end

    assign o_out_valid           = r_out_valid;
    assign o_out_item.red_out    = r_rd_data[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
    assign o_out_item.green_out  = r_rd_data[2*CHANNEL_BITS-1:CHANNEL_BITS];
    assign o_out_item.blue_out   = r_rd_data[CHANNEL_BITS-1:0];
    assign o_out_item.out_col    = r_out_col;
    assign o_out_item.out_row    = r_out_row;
    assign o_out_item.frame_last = r_out_last;

endmodule

`default_nettype wire
